/* hw/rtl/assert_macros.svh */
// Assertion macros used by the send-window top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/srsw_pkg.sv */
// Constants and types of the selective-repeat send window.
package srsw_pkg;

	localparam int WIN_SLOTS = 8;
	localparam int PKT_BYTES = 512;

	localparam int FS_W   = 32;
	localparam int IDX_W  = 24;
	localparam int CNT_W  = IDX_W + 1;
	localparam int PAY_W  = 10;
	localparam int PKT_W  = $clog2(PKT_BYTES + 1);
	localparam int OFF_W  = (CNT_W + PKT_W > FS_W + 1) ? CNT_W + PKT_W : FS_W + 1;
	localparam int SLOT_W = (WIN_SLOTS > 1) ? $clog2(WIN_SLOTS) : 1;

	localparam logic [CNT_W-1:0] IDX_LIMIT = CNT_W'(1) << IDX_W;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_SENT  = 2'd1;
	localparam logic [1:0] ST_ACKED = 2'd2;

	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	localparam logic KIND_DESC = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	typedef struct packed {
		logic [PAY_W-1:0] payload;
		logic             is_final;
	} desc_t;

endpackage

/* hw/rtl/selective_repeat_send_window.sv */
// Top level of the selective-repeat send window: sequencer and slot state.
//
// Command channel: an item (cmd, ack_offset) is taken when start is high and
// busy is low. busy stays high until the item's last result has been issued.
// Results: each result sits on the output ports for one cycle with strobe
// high; the receiver cannot stall, so nothing is held back.
// Config: cfg_data is written to file_size when cfg_valid is high; cfg_ready
// is always high. Write it only while busy is low.
// Send pass: the idle state loads the walk (slot, index, offset, emit mask),
// then S_SEND walks the window slots in order up to the last slot that
// emits a descriptor; a pass that emits nothing stays idle and issues no
// result. The slot walk goes through the descriptor unit.
// Ack: the idle state captures the packet number, S_ACK checks it and marks
// the slot, S_FIN builds the status result. A slide puts S_SLIDE between
// S_ACK and S_FIN, moving the window one slot at a time.
// Reset: all slots free, window base zero, file_size zero. No clearing pass.
`include "assert_macros.svh"

module selective_repeat_send_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [31:0]                   ack_offset,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srsw_pkg::FS_W-1:0]     cfg_data,
	output logic                          strobe,
	output logic                          kind,
	output logic [srsw_pkg::IDX_W-1:0]    packet_index,
	output logic [31:0]                   byte_offset,
	output logic [srsw_pkg::PAY_W-1:0]    payload_bytes,
	output logic                          is_final_packet,
	output logic                          relay_odd,
	output logic                          end_of_run,
	output logic [srsw_pkg::IDX_W-1:0]    window_base,
	output logic                          ack_rejected,
	output logic                          finished
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SEND  = 3'd1;
	localparam logic [2:0] S_ACK   = 3'd2;
	localparam logic [2:0] S_SLIDE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam int W   = srsw_pkg::WIN_SLOTS;
	localparam int CW  = srsw_pkg::CNT_W;
	localparam int OW  = srsw_pkg::OFF_W;
	localparam int SW  = srsw_pkg::SLOT_W;
	localparam int FW  = srsw_pkg::FS_W;
	localparam int IW  = srsw_pkg::IDX_W;

	logic [2:0]    state_q;
	logic [1:0]    status_q [W];
	logic [IW-1:0] ws_q;
	logic [FW-1:0] fs_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] fin_q;

	logic [SW-1:0] slot_q;
	logic [CW-1:0] idx_q;
	logic [OW-1:0] off_q;
	logic [W-1:0]  emit_q;
	logic [FW-1:0] pkt_q;
	logic [CW-1:0] room_q;
	logic          rej_q;

	logic          strobe_q;
	logic          kind_q;
	logic [IW-1:0] pidx_q;
	logic [31:0]   boff_q;
	logic [srsw_pkg::PAY_W-1:0] pay_q;
	logic          final_q;
	logic          odd_q;
	logic          eor_q;
	logic [IW-1:0] base_q;
	logic          arej_q;
	logic          done_q;

	logic [FW:0]   cfg_sum;
	logic [FW:0]   cfg_quo;
	logic [CW-1:0] cfg_cnt;
	logic [CW-1:0] cfg_fin;
	logic [CW-1:0] ws_ext;
	logic [CW-1:0] avail;
	logic [W-1:0]  emit_d;
	logic          last_emit;
	logic          ack_rej;
	logic [SW-1:0] rel;
	logic          all_acked;
	srsw_pkg::desc_t desc;

	srsw_desc u_desc (
		.fs   (fs_q),
		.cnt  (cnt_q),
		.idx  (idx_q),
		.off  (off_q),
		.desc (desc)
	);

	always_comb begin
		cfg_sum = {1'b0, cfg_data} + (FW + 1)'(srsw_pkg::PKT_BYTES - 1);
		cfg_quo = cfg_sum / srsw_pkg::PKT_BYTES;
		cfg_cnt = (cfg_quo > (FW + 1)'(srsw_pkg::IDX_LIMIT)) ? srsw_pkg::IDX_LIMIT
			: cfg_quo[CW-1:0];
		cfg_fin = (cfg_cnt > CW'(W)) ? cfg_cnt - CW'(W) : '0;

		ws_ext = {1'b0, ws_q};
		avail = (cnt_q > ws_ext) ? cnt_q - ws_ext : '0;
		all_acked = 1'b1;
		for (int i = 0; i < W; i++) begin
			emit_d[i] = (status_q[i] == srsw_pkg::ST_FREE) && (CW'(i) < avail);
			if ((CW'(i) < avail) && (status_q[i] != srsw_pkg::ST_ACKED))
				all_acked = 1'b0;
		end
		last_emit = (emit_q & ~(W'(1) << slot_q)) == '0;

		ack_rej = (pkt_q < FW'(ws_q)) || (pkt_q >= FW'(ws_ext + CW'(W)))
			|| (pkt_q >= FW'(cnt_q));
		rel = pkt_q[SW-1:0] - ws_q[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < W; i++)
				status_q[i] <= srsw_pkg::ST_FREE;
			ws_q <= '0;
			fs_q <= '0;
			cnt_q <= '0;
			fin_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) begin
				fs_q <= cfg_data;
				cnt_q <= cfg_cnt;
				fin_q <= cfg_fin;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd == srsw_pkg::CMD_SEND) begin
							slot_q <= '0;
							idx_q <= ws_ext;
							off_q <= OW'(ws_q) * OW'(srsw_pkg::PKT_BYTES);
							emit_q <= emit_d;
							state_q <= (emit_d != '0) ? S_SEND : S_IDLE;
						end else begin
							pkt_q <= ack_offset / srsw_pkg::PKT_BYTES;
							state_q <= S_ACK;
						end
					end
				end
				S_SEND: begin
					if (emit_q[slot_q]) begin
						strobe_q <= 1'b1;
						kind_q <= srsw_pkg::KIND_DESC;
						pidx_q <= idx_q[IW-1:0];
						boff_q <= off_q[31:0];
						pay_q <= desc.payload;
						final_q <= desc.is_final;
						odd_q <= idx_q[0];
						eor_q <= last_emit;
						base_q <= ws_q;
						arej_q <= 1'b0;
						done_q <= 1'b0;
						status_q[slot_q] <= srsw_pkg::ST_SENT;
						emit_q[slot_q] <= 1'b0;
					end
					if (last_emit) begin
						state_q <= S_IDLE;
					end else begin
						slot_q <= slot_q + SW'(1);
						idx_q <= idx_q + CW'(1);
						off_q <= off_q + OW'(srsw_pkg::PKT_BYTES);
					end
				end
				S_ACK: begin
					rej_q <= ack_rej;
					state_q <= S_FIN;
					if (!ack_rej) begin
						status_q[rel] <= srsw_pkg::ST_ACKED;
						if ((pkt_q == FW'(ws_q)) && (ws_ext < fin_q)) begin
							room_q <= fin_q - ws_ext;
							state_q <= S_SLIDE;
						end
					end
				end
				S_SLIDE: begin
					if ((status_q[0] == srsw_pkg::ST_ACKED) && (room_q != '0)) begin
						for (int i = 0; i < W - 1; i++)
							status_q[i] <= status_q[i+1];
						status_q[W-1] <= srsw_pkg::ST_FREE;
						ws_q <= ws_q + IW'(1);
						room_q <= room_q - CW'(1);
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					strobe_q <= 1'b1;
					kind_q <= srsw_pkg::KIND_ACK;
					pidx_q <= '0;
					boff_q <= '0;
					pay_q <= '0;
					final_q <= 1'b0;
					odd_q <= 1'b0;
					eor_q <= 1'b1;
					base_q <= ws_q;
					arej_q <= rej_q;
					done_q <= (ws_ext == fin_q) && all_acked;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = state_q != S_IDLE;
	assign cfg_ready       = 1'b1;
	assign strobe          = strobe_q;
	assign kind            = kind_q;
	assign packet_index    = pidx_q;
	assign byte_offset     = boff_q;
	assign payload_bytes   = pay_q;
	assign is_final_packet = final_q;
	assign relay_odd       = odd_q;
	assign end_of_run      = eor_q;
	assign window_base     = base_q;
	assign ack_rejected    = arej_q;
	assign finished        = done_q;

	`ASSERT_AT(a_ack_goes_busy, clk, arst_n, start && !busy && cmd |=> busy)
	`ASSERT_NEVER(a_desc_no_status, clk, arst_n, strobe && !kind && (ack_rejected || finished))
	`ASSERT_AT(a_desc_parity, clk, arst_n, strobe && !kind |-> relay_odd == packet_index[0])
	`ASSERT_AT(a_ack_single, clk, arst_n, strobe && kind |-> end_of_run && !busy)

endmodule

/* hw/rtl/srsw_desc.sv */
// Descriptor unit: payload length and last-packet flag for one packet.
module srsw_desc (
	input  logic [srsw_pkg::FS_W-1:0]  fs,
	input  logic [srsw_pkg::CNT_W-1:0] cnt,
	input  logic [srsw_pkg::CNT_W-1:0] idx,
	input  logic [srsw_pkg::OFF_W-1:0] off,
	output srsw_pkg::desc_t            desc
);

	logic [srsw_pkg::OFF_W-1:0] fs_ext;
	logic [srsw_pkg::OFF_W-1:0] rem;
	logic [srsw_pkg::OFF_W-1:0] pay;

	always_comb begin
		fs_ext = srsw_pkg::OFF_W'(fs);
		rem = (fs_ext > off) ? fs_ext - off : '0;
		pay = (rem < srsw_pkg::OFF_W'(srsw_pkg::PKT_BYTES)) ? rem
			: srsw_pkg::OFF_W'(srsw_pkg::PKT_BYTES);
		desc.payload = pay[srsw_pkg::PAY_W-1:0];
		desc.is_final = (idx + srsw_pkg::CNT_W'(1)) == cnt;
	end

endmodule
